// File: src/msd_pkg.sv
// ------------------------------------------------------------------------------------------
// msd_pkg: shared types and constants of the move step distributor
// Field widths, transaction structs, count modes and the magnitude helper.
// ------------------------------------------------------------------------------------------
package msd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAME_BITS = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(COORD_BITS);
  localparam int CEIL_W     = (COORD_BITS > FRAME_BITS) ? COORD_BITS + 1 : FRAME_BITS + 1;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [FRAME_BITS-1:0] frame_t;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_SPEED = 2'd1,
    MODE_CLAMP = 2'd2
  } count_mode_e;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] RST_COUNT_MODE   = MODE_SPEED;
  localparam frame_t     RST_FIXED_FRAMES = FRAME_BITS'(30);
  localparam frame_t     RST_SPEED        = FRAME_BITS'(4);
  localparam frame_t     RST_MIN_FRAMES   = FRAME_BITS'(1);
  localparam frame_t     RST_MAX_FRAMES   = FRAME_BITS'(120);

  typedef struct packed {
    logic   command;
    coord_t delta_x;
    coord_t delta_y;
  } in_item_t;

  typedef struct packed {
    coord_t step_x;
    coord_t step_y;
    logic   more;
    frame_t total_frames;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count_mode;
    frame_t     fixed_frames;
    frame_t     speed;
    frame_t     min_frames;
    frame_t     max_frames;
  } cfg_t;

  typedef struct packed {
    logic   start;
    mag_t   dividend;
    frame_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    mag_t   quotient;
    frame_t remainder;
  } div_rsp_t;

  function automatic mag_t coord_abs(input coord_t v);
    mag_t m;
    m = mag_t'(v);
    return v[COORD_BITS-1] ? (~m + mag_t'(1)) : m;
  endfunction

endpackage

// File: src/msd_serial_div.sv
// ------------------------------------------------------------------------------------------
// msd_serial_div: bit-serial restoring divider
// Unsigned magnitude by frame-width divisor, one quotient bit per cycle.
// ------------------------------------------------------------------------------------------
module msd_serial_div (
  input  logic             clk,
  input  logic             rst_n,
  input  msd_pkg::div_req_t req,
  output msd_pkg::div_rsp_t rsp
);
  import msd_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  frame_t                rem_r, rem_nxt;
  mag_t                  quo_r, quo_nxt;
  frame_t                den_r, den_nxt;

  logic [FRAME_BITS:0]   trial;
  logic [FRAME_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[COORD_BITS-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(COORD_BITS - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
      quo_nxt = {quo_r[COORD_BITS-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// File: src/msd_cfg_regs.sv
// ------------------------------------------------------------------------------------------
// msd_cfg_regs: configuration register file
// APB-style write and read-back of the count mode, fixed count, speed and limits.
// ------------------------------------------------------------------------------------------
module msd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [msd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [msd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output msd_pkg::cfg_t                 cfg
);
  import msd_pkg::*;

  localparam logic [2:0] REG_COUNT_MODE   = 3'd0;
  localparam logic [2:0] REG_FIXED_FRAMES = 3'd1;
  localparam logic [2:0] REG_SPEED        = 3'd2;
  localparam logic [2:0] REG_MIN_FRAMES   = 3'd3;
  localparam logic [2:0] REG_MAX_FRAMES   = 3'd4;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_COUNT_MODE:   cfg_nxt.count_mode   = pwdata[1:0];
        REG_FIXED_FRAMES: cfg_nxt.fixed_frames = pwdata[FRAME_BITS-1:0];
        REG_SPEED:        cfg_nxt.speed        = pwdata[FRAME_BITS-1:0];
        REG_MIN_FRAMES:   cfg_nxt.min_frames   = pwdata[FRAME_BITS-1:0];
        REG_MAX_FRAMES:   cfg_nxt.max_frames   = pwdata[FRAME_BITS-1:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COUNT_MODE:   prdata = CFG_DATA_W'(cfg_r.count_mode);
      REG_FIXED_FRAMES: prdata = CFG_DATA_W'(cfg_r.fixed_frames);
      REG_SPEED:        prdata = CFG_DATA_W'(cfg_r.speed);
      REG_MIN_FRAMES:   prdata = CFG_DATA_W'(cfg_r.min_frames);
      REG_MAX_FRAMES:   prdata = CFG_DATA_W'(cfg_r.max_frames);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_mode   <= RST_COUNT_MODE;
      cfg_r.fixed_frames <= RST_FIXED_FRAMES;
      cfg_r.speed        <= RST_SPEED;
      cfg_r.min_frames   <= RST_MIN_FRAMES;
      cfg_r.max_frames   <= RST_MAX_FRAMES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

// File: src/move_step_distributor_unit.sv
// ------------------------------------------------------------------------------------------
// move_step_distributor_unit: even split of a linear move over animation frames
// Start transactions size a move and split both deltas by the frame count on a
// shared bit-serial divider; tick transactions return the step of each frame.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_item_t  (command, delta_x, delta_y)
//   out_    | output    | out_valid/out_stall | out_item_t (step_x, step_y, more, total)
//   cfg     | input     | psel/penable/pready | 32-bit registers at 4*index
//
// tick: the step is registered in res_r, then passed to the output register in S_DONE;
//   the next transaction is taken once the unit is back in S_IDLE
// start: speed modes size the frame count on the shared divider first; both deltas are then
//   split on it, one quotient bit per cycle, and a zero frame count skips the splits
// reset: synchronous, clears the move state and loads the register defaults
// out_stall holds the output register; one further transaction is taken and
//   finished meanwhile, then in_stall stays high until the output frees
// ------------------------------------------------------------------------------------------
module move_step_distributor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  msd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output msd_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [msd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [msd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import msd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_PREP,
    S_DIV_X,
    S_DIV_Y,
    S_DONE
  } state_t;

  cfg_t      cfg;
  div_req_t  div_req_r, div_req_nxt;
  div_rsp_t  div_rsp;

  state_t    state_r, state_nxt;
  coord_t    dx_r, dx_nxt;
  coord_t    dy_r, dy_nxt;
  frame_t    f_r, f_nxt;
  frame_t    frame_total_r, frame_total_nxt;
  frame_t    frame_index_r, frame_index_nxt;
  coord_t    quot_x_r, quot_x_nxt;
  coord_t    quot_y_r, quot_y_nxt;
  frame_t    rem_x_r, rem_x_nxt;
  frame_t    rem_y_r, rem_y_nxt;
  logic      moving_r, moving_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  mag_t                in_abs_x, in_abs_y;
  logic [CEIL_W-1:0]   ceil_w;
  frame_t              count_sat;
  frame_t              count_lim;
  logic                split_neg;
  coord_t              split_q;
  frame_t              split_r;
  logic [FRAME_BITS:0] idx_inc;
  logic                tick_more;
  coord_t              tick_sx, tick_sy;

  msd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msd_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign in_abs_x = coord_abs(in_data.delta_x);
  assign in_abs_y = coord_abs(in_data.delta_y);

  // ceiling of the larger magnitude over speed, saturated, and clamped in clamp mode
  assign ceil_w    = CEIL_W'(div_rsp.quotient) + CEIL_W'(div_rsp.remainder != '0);
  assign count_sat = (ceil_w > CEIL_W'(FRAME_MAX)) ? FRAME_MAX : ceil_w[FRAME_BITS-1:0];

  always_comb begin
    count_lim = count_sat;
    if (cfg.count_mode == MODE_CLAMP) begin
      if (count_lim < cfg.min_frames) count_lim = cfg.min_frames;
      if (count_lim > cfg.max_frames) count_lim = cfg.max_frames;
    end
  end

  // floor division from the magnitude quotient
  assign split_neg = (state_r == S_DIV_X) ? dx_r[COORD_BITS-1] : dy_r[COORD_BITS-1];

  always_comb begin
    if (!split_neg) begin
      split_q = coord_t'(div_rsp.quotient);
      split_r = div_rsp.remainder;
    end else if (div_rsp.remainder == '0) begin
      split_q = coord_t'(~div_rsp.quotient + mag_t'(1));
      split_r = '0;
    end else begin
      split_q = coord_t'(~div_rsp.quotient);
      split_r = f_r - div_rsp.remainder;
    end
  end

  assign idx_inc   = (FRAME_BITS+1)'(frame_index_r) + (FRAME_BITS+1)'(1);
  assign tick_more = moving_r && (idx_inc < (FRAME_BITS+1)'(frame_total_r));
  assign tick_sx   = !moving_r ? '0 :
                     (frame_index_r < rem_x_r) ? quot_x_r + coord_t'(1) : quot_x_r;
  assign tick_sy   = !moving_r ? '0 :
                     (frame_index_r < rem_y_r) ? quot_y_r + coord_t'(1) : quot_y_r;

  always_comb begin
    state_nxt         = state_r;
    dx_nxt            = dx_r;
    dy_nxt            = dy_r;
    f_nxt             = f_r;
    frame_total_nxt   = frame_total_r;
    frame_index_nxt   = frame_index_r;
    quot_x_nxt        = quot_x_r;
    quot_y_nxt        = quot_y_r;
    rem_x_nxt         = rem_x_r;
    rem_y_nxt         = rem_y_r;
    moving_nxt        = moving_r;
    res_nxt           = res_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r;
    div_req_nxt       = div_req_r;
    div_req_nxt.start = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_START) begin
            dx_nxt = in_data.delta_x;
            dy_nxt = in_data.delta_y;
            if (cfg.count_mode == MODE_FIXED) begin
              f_nxt     = cfg.fixed_frames;
              state_nxt = S_PREP;
            end else begin
              div_req_nxt.start    = 1'b1;
              div_req_nxt.dividend = (in_abs_x > in_abs_y) ? in_abs_x : in_abs_y;
              div_req_nxt.divisor  = (cfg.speed == '0) ? FRAME_BITS'(1) : cfg.speed;
              state_nxt            = S_COUNT;
            end
          end else begin
            res_nxt.step_x       = tick_sx;
            res_nxt.step_y       = tick_sy;
            res_nxt.more         = tick_more;
            res_nxt.total_frames = frame_total_r;
            if (tick_more) frame_index_nxt = idx_inc[FRAME_BITS-1:0];
            else           moving_nxt      = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_COUNT: begin
        if (div_rsp.done) begin
          f_nxt     = count_lim;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        frame_total_nxt = f_r;
        frame_index_nxt = '0;
        if (f_r == '0) begin
          quot_x_nxt = '0;
          quot_y_nxt = '0;
          rem_x_nxt  = '0;
          rem_y_nxt  = '0;
          moving_nxt = 1'b0;
          res_nxt    = '{step_x: '0, step_y: '0, more: 1'b0, total_frames: f_r};
          state_nxt  = S_DONE;
        end else begin
          div_req_nxt.start    = 1'b1;
          div_req_nxt.dividend = coord_abs(dx_r);
          div_req_nxt.divisor  = f_r;
          state_nxt            = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          quot_x_nxt           = split_q;
          rem_x_nxt            = split_r;
          div_req_nxt.start    = 1'b1;
          div_req_nxt.dividend = coord_abs(dy_r);
          div_req_nxt.divisor  = f_r;
          state_nxt            = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_rsp.done) begin
          quot_y_nxt = split_q;
          rem_y_nxt  = split_r;
          moving_nxt = 1'b1;
          res_nxt    = '{step_x: '0, step_y: '0, more: 1'b1, total_frames: f_r};
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      frame_total_r     <= '0;
      frame_index_r     <= '0;
      quot_x_r          <= '0;
      quot_y_r          <= '0;
      rem_x_r           <= '0;
      rem_y_r           <= '0;
      moving_r          <= 1'b0;
      out_valid_r       <= 1'b0;
      div_req_r.start   <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      frame_total_r     <= frame_total_nxt;
      frame_index_r     <= frame_index_nxt;
      quot_x_r          <= quot_x_nxt;
      quot_y_r          <= quot_y_nxt;
      rem_x_r           <= rem_x_nxt;
      rem_y_r           <= rem_y_nxt;
      moving_r          <= moving_nxt;
      out_valid_r       <= out_valid_nxt;
      div_req_r.start   <= div_req_nxt.start;
    end
    dx_r                 <= dx_nxt;
    dy_r                 <= dy_nxt;
    f_r                  <= f_nxt;
    res_r                <= res_nxt;
    out_r                <= out_nxt;
    div_req_r.dividend   <= div_req_nxt.dividend;
    div_req_r.divisor    <= div_req_nxt.divisor;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/msd_checker.sv
// ------------------------------------------------------------------------------------------
// msd_checker: port-level checks of the move step distributor
// Watches handshakes and result fields over time; bound to the top level.
// ------------------------------------------------------------------------------------------
module msd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input msd_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_stall
);
  import msd_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one transaction at a time in the datapath
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

  // a fresh result only comes from a transaction in flight
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in flight");

  // no frame count, no movement
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.total_frames == '0) |->
      (out_data.step_x == '0) && (out_data.step_y == '0) && !out_data.more)
    else $error("step with zero frame count");

endmodule

bind move_step_distributor_unit msd_checker u_msd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
